### hw/rtl/vbalz_pkg.sv
// shared types, constants and helpers of the vba lz window decompressor
`default_nettype none

package vbalz_pkg;

  // window geometry
  localparam int WIN_BYTES = 4096;
  localparam int WIN_AW    = $clog2(WIN_BYTES);

  // pending copy count holds up to a full window plus the minimum length
  localparam int CNT_W    = 13;
  localparam int COPY_MIN = 3;

  // container signature and chunk header compressed flag (bit 7 of the high byte)
  localparam logic [7:0] SIG_BYTE      = 8'h01;
  localparam int         HDR_COMP_BIT  = 7;

  // request kinds
  localparam logic FN_PUSH    = 1'b0;
  localparam logic FN_ADVANCE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SIG = 2'd1,
    ST_BUSY    = 2'd2
  } status_t;

  // one request as decoded by the parser, handed to the window stage
  typedef struct packed {
    logic              res;
    logic              wr;
    logic              use_ram;
    logic [WIN_AW-1:0] rd_addr;
    logic [WIN_AW-1:0] wr_addr;
    logic [7:0]        lit;
    logic [CNT_W-1:0]  copy_left;
    status_t           status;
  } vbalz_req_t;

  // length/distance split of a copy token: 12 minus thresholds passed
  function automatic logic [3:0] tok_shift(input logic [WIN_AW-1:0] pos);
    logic [3:0] n;
    n = 4'd12;
    for (int k = 0; k < 8; k++) begin
      if (pos > (WIN_AW'(16) << k)) begin
        n = n - 4'd1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/vba_lz_window_decompressor.sv
// top level: parser, window memory stage and output register
//
//  channel | dir | handshake          | payload
//  in_*    | in  | tvalid/tready      | tuser=func, tdata=in_byte, tlast=in_last
//  out_*   | out | tvalid/tready      | tdata=out_byte,copy_left; tuser=status
//
// one request per cycle sustained while the output takes results; a result is registered
// in the window stage (window memory read), then in the output register
// a copy byte reads and writes the window; the byte written just before is forwarded
// the window clears by fill tracking, so no clearing pass after reset or signature
// output stall holds the window stage, and the input stalls only when that stage is full
`default_nettype none

module vba_lz_window_decompressor
  import vbalz_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tuser,   // [0] func
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // [7:0] out_byte, [20:8] copy_left, [23:21] zero
  output logic      [1:0]  out_tuser   // [1:0] status
);

  vbalz_req_t        req;
  logic              accept;
  logic              out_free;
  logic              s1_adv;
  logic              fwd;
  logic [7:0]        s1_byte;
  logic [7:0]        ram_rdata;

  // window stage registers
  logic              s1_valid_r;
  logic              s1_wr_r;
  logic              s1_use_ram_r;
  logic [WIN_AW-1:0] s1_wr_addr_r;
  logic [7:0]        s1_lit_r;
  logic [CNT_W-1:0]  s1_copy_left_r;
  status_t           s1_status_r;

  // output registers
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic [CNT_W-1:0]  out_copy_left_r;
  status_t           out_status_r;

  // flow control
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign accept    = in_tvalid && in_tready;

  vbalz_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .func    (in_tuser),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .req     (req)
  );

  // window byte of the stage: memory data or literal
  assign s1_byte = s1_use_ram_r ? ram_rdata : s1_lit_r;

  // same entry written this cycle as the new read: take the written byte
  assign fwd = s1_adv && s1_wr_r && (s1_wr_addr_r == req.rd_addr);

  vbalz_ram #(
    .WIDTH (8),
    .DEPTH (WIN_BYTES)
  ) u_window (
    .clk   (clk),
    .we    (s1_adv && s1_wr_r),
    .waddr (s1_wr_addr_r),
    .wdata (s1_byte),
    .re    (accept),
    .raddr (req.rd_addr),
    .rdata (ram_rdata)
  );

  // window stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= req.res;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_wr_r        <= req.wr;
      s1_wr_addr_r   <= req.wr_addr;
      s1_use_ram_r   <= req.use_ram && !fwd;
      s1_lit_r       <= (req.use_ram && fwd) ? s1_byte : req.lit;
      s1_copy_left_r <= req.copy_left;
      s1_status_r    <= req.status;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte_r      <= s1_byte;
      out_copy_left_r <= s1_copy_left_r;
      out_status_r    <= s1_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_copy_left_r, out_byte_r};
  assign out_tuser  = out_status_r;

  // a full window stage behind a stalled output blocks new requests
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("request taken while the window stage is stalled");

  // error results carry a zero byte
  a_error_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_byte_r == 8'h00))
    else $error("error result with nonzero byte");

  // a refused push only happens while a copy is pending
  a_busy_has_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_BUSY)) |-> (out_copy_left_r != '0))
    else $error("busy status with no pending copy");

  // pending copy never exceeds a window plus the minimum length
  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_copy_left_r <= CNT_W'(WIN_BYTES + COPY_MIN - 1)))
    else $error("pending copy count out of range");

  // a stage entry that did not move on keeps its place
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> s1_valid_r)
    else $error("window stage entry lost");

endmodule

`default_nettype wire

### hw/rtl/vbalz_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module vbalz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/vbalz_parse.sv
// container parser: chunk headers, flag bytes, tokens and window position
`default_nettype none

module vbalz_parse
  import vbalz_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic       func,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output vbalz_req_t      req
);

  typedef enum logic [2:0] {
    PH_AWAIT    = 3'd0,
    PH_HDR_LO   = 3'd1,
    PH_HDR_HI   = 3'd2,
    PH_RAW      = 3'd3,
    PH_FLAG     = 3'd4,
    PH_ITEM     = 3'd5,
    PH_TOKEN_HI = 3'd6
  } phase_t;

  phase_t            phase_r,     phase_nxt;
  logic [WIN_AW-1:0] pos_r,       pos_nxt;
  logic              pos_nz_r,    pos_nz_nxt;
  logic              wrapped_r,   wrapped_nxt;
  logic [7:0]        flag_bits_r, flag_bits_nxt;
  logic [2:0]        flag_idx_r,  flag_idx_nxt;
  logic [7:0]        tok_lo_r,    tok_lo_nxt;
  logic [CNT_W-1:0]  cnt_r,       cnt_nxt;
  logic [WIN_AW-1:0] dist_r,      dist_nxt;
  logic              bclean_r,    bclean_nxt;

  logic [WIN_AW-1:0] src_addr;
  logic [15:0]       tok;
  logic [15:0]       tok_len;
  logic [3:0]        sh;

  // copy source, one behind the distance
  assign src_addr = pos_r - dist_r - WIN_AW'(1);
  assign tok      = {in_byte, tok_lo_r};
  assign sh       = tok_shift(pos_r);
  assign tok_len  = tok & ~(16'hFFFF << sh);

  // decode of one request and next parser state
  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    pos_nz_nxt    = pos_nz_r;
    wrapped_nxt   = wrapped_r;
    flag_bits_nxt = flag_bits_r;
    flag_idx_nxt  = flag_idx_r;
    tok_lo_nxt    = tok_lo_r;
    cnt_nxt       = cnt_r;
    dist_nxt      = dist_r;
    bclean_nxt    = bclean_r;

    req           = '0;
    req.status    = ST_OK;
    req.rd_addr   = src_addr;
    req.wr_addr   = pos_r;
    req.copy_left = cnt_r;

    if (func == FN_ADVANCE) begin
      // one copied byte out of the window; unwritten entries read as zero
      if (cnt_r != '0) begin
        req.res       = 1'b1;
        req.wr        = 1'b1;
        req.use_ram   = wrapped_r || (src_addr < pos_r);
        cnt_nxt       = cnt_r - CNT_W'(1);
        req.copy_left = cnt_nxt;
        pos_nxt       = pos_r + WIN_AW'(1);
        pos_nz_nxt    = 1'b1;
        wrapped_nxt   = wrapped_r || (pos_r == '1);
      end
    end else if (cnt_r != '0) begin
      // push refused while a copy is still pending
      req.res    = 1'b1;
      req.status = ST_BUSY;
    end else begin
      case (phase_r)
        PH_AWAIT: begin
          if (in_byte != SIG_BYTE) begin
            req.res    = 1'b1;
            req.status = ST_BAD_SIG;
          end else begin
            pos_nxt       = '0;
            pos_nz_nxt    = 1'b0;
            wrapped_nxt   = 1'b0;
            flag_bits_nxt = '0;
            flag_idx_nxt  = '0;
            bclean_nxt    = 1'b1;
            phase_nxt     = PH_HDR_LO;
          end
        end
        PH_HDR_LO: begin
          tok_lo_nxt = in_byte;
          phase_nxt  = PH_HDR_HI;
        end
        PH_HDR_HI: begin
          flag_idx_nxt = '0;
          phase_nxt    = in_byte[HDR_COMP_BIT] ? PH_FLAG : PH_RAW;
        end
        PH_RAW: begin
          req.res     = 1'b1;
          req.wr      = 1'b1;
          req.lit     = in_byte;
          pos_nxt     = pos_r + WIN_AW'(1);
          pos_nz_nxt  = 1'b1;
          wrapped_nxt = wrapped_r || (pos_r == '1);
        end
        PH_FLAG: begin
          flag_bits_nxt = in_byte;
          flag_idx_nxt  = '0;
          phase_nxt     = PH_ITEM;
        end
        PH_ITEM: begin
          if (flag_bits_r[flag_idx_r]) begin
            tok_lo_nxt = in_byte;
            phase_nxt  = PH_TOKEN_HI;
          end else if (pos_nz_r && (pos_r == '0) && bclean_r) begin
            // window boundary: this byte opens a new chunk header
            tok_lo_nxt = in_byte;
            bclean_nxt = 1'b0;
            phase_nxt  = PH_HDR_HI;
          end else begin
            req.res     = 1'b1;
            req.wr      = 1'b1;
            req.lit     = in_byte;
            pos_nxt     = pos_r + WIN_AW'(1);
            pos_nz_nxt  = 1'b1;
            wrapped_nxt = wrapped_r || (pos_r == '1);
            bclean_nxt  = 1'b1;
            if (flag_idx_r == 3'd7) begin
              flag_idx_nxt = '0;
              phase_nxt    = PH_FLAG;
            end else begin
              flag_idx_nxt = flag_idx_r + 3'd1;
              phase_nxt    = PH_ITEM;
            end
          end
        end
        PH_TOKEN_HI: begin
          cnt_nxt    = CNT_W'(tok_len[WIN_AW-1:0]) + CNT_W'(COPY_MIN);
          dist_nxt   = WIN_AW'(tok >> sh);
          bclean_nxt = 1'b1;
          if (flag_idx_r == 3'd7) begin
            flag_idx_nxt = '0;
            phase_nxt    = PH_FLAG;
          end else begin
            flag_idx_nxt = flag_idx_r + 3'd1;
            phase_nxt    = PH_ITEM;
          end
        end
        default: begin
          phase_nxt = PH_AWAIT;
        end
      endcase
      if (in_last) begin
        phase_nxt = PH_AWAIT;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_AWAIT;
      pos_r       <= '0;
      pos_nz_r    <= 1'b0;
      wrapped_r   <= 1'b0;
      flag_bits_r <= '0;
      flag_idx_r  <= '0;
      tok_lo_r    <= '0;
      cnt_r       <= '0;
      dist_r      <= '0;
      bclean_r    <= 1'b1;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      pos_nz_r    <= pos_nz_nxt;
      wrapped_r   <= wrapped_nxt;
      flag_bits_r <= flag_bits_nxt;
      flag_idx_r  <= flag_idx_nxt;
      tok_lo_r    <= tok_lo_nxt;
      cnt_r       <= cnt_nxt;
      dist_r      <= dist_nxt;
      bclean_r    <= bclean_nxt;
    end
  end

endmodule

`default_nettype wire
